@@ design/cfd_pkg.sv @@
// package for the checksummed frame deframer
// holds header, result kind and position codes, the decoded result struct and is_header; no dependencies
`default_nettype none

package cfd_pkg;

    localparam logic [7:0] HDR_ADC   = 8'h81;
    localparam logic [7:0] HDR_FREQ  = 8'ha1;
    localparam logic [7:0] HDR_WACK  = 8'hb1;
    localparam logic [7:0] HDR_POWER = 8'hc1;
    localparam logic [7:0] HDR_EACK  = 8'he1;

    localparam logic [2:0] KIND_ADC   = 3'd0;
    localparam logic [2:0] KIND_FREQ  = 3'd1;
    localparam logic [2:0] KIND_MASK  = 3'd2;
    localparam logic [2:0] KIND_POWER = 3'd3;
    localparam logic [2:0] KIND_WACK  = 3'd4;
    localparam logic [2:0] KIND_EACK  = 3'd5;

    localparam logic [1:0] POS_HUNT  = 2'd0;
    localparam logic [1:0] POS_BODY0 = 2'd1;
    localparam logic [1:0] POS_BODY1 = 2'd2;
    localparam logic [1:0] POS_CSUM  = 2'd3;

    typedef struct packed {
        logic [2:0] frame_kind;
        logic [2:0] channel;
        logic [9:0] adc_value;
        logic [7:0] body_first;
        logic [7:0] body_second;
    } cfd_result_t;

    function automatic logic is_header(input logic [7:0] b);
        return (b == HDR_ADC) || (b == HDR_FREQ) || (b == HDR_WACK)
            || (b == HDR_POWER) || (b == HDR_EACK);
    endfunction

endpackage

`default_nettype wire

@@ design/checksummed_frame_deframer_top.sv @@
// latency: a result appears in the cycle after its checksum byte is accepted, if the checksum matches
// throughput: one byte per cycle; only the checksum byte waits while a result is stalled
// the single result register sets the rate; frame bytes are held in registers
// reset: asynchronous active low, returns to hunting for a header with no result pending
// top level of the checksummed frame deframer; uses cfd_pkg and cfd_decode
`default_nettype none

module checksummed_frame_deframer_top
    import cfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic [2:0]      frame_kind,
    output logic [2:0]      channel,
    output logic [9:0]      adc_value,
    output logic [7:0]      body_first,
    output logic [7:0]      body_second
);

    logic [1:0]  pos_reg, pos_next;
    logic [7:0]  header_reg, header_next;
    logic [7:0]  body0_reg, body0_next;
    logic [7:0]  body1_reg, body1_next;
    logic        valid_reg, valid_next;
    cfd_result_t result_reg, result_next;
    cfd_result_t decoded;
    logic        rx_take;
    logic        out_take;
    logic [7:0]  csum;

    cfd_decode u_decode (
        .header (header_reg),
        .body0  (body0_reg),
        .body1  (body1_reg),
        .result (decoded)
    );

    // only a checksum item can produce a result, so only it must wait
    assign rx_stall = valid_reg && res_stall && (pos_reg == POS_CSUM);
    assign rx_take  = rx_valid && !rx_stall;
    assign out_take = valid_reg && !res_stall;
    assign csum     = header_reg + body0_reg + body1_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        body0_next  = body0_reg;
        body1_next  = body1_reg;
        valid_next  = out_take ? 1'b0 : valid_reg;
        result_next = result_reg;
        if (rx_take)
        begin
            unique case (pos_reg)
                POS_HUNT:
                begin
                    if (is_header(rx_byte))
                    begin
                        header_next = rx_byte;
                        pos_next    = POS_BODY0;
                    end
                end
                POS_BODY0:
                begin
                    body0_next = rx_byte;
                    pos_next   = POS_BODY1;
                end
                POS_BODY1:
                begin
                    body1_next = rx_byte;
                    pos_next   = POS_CSUM;
                end
                default:
                begin
                    pos_next = POS_HUNT;
                    if (csum == rx_byte)
                    begin
                        valid_next  = 1'b1;
                        result_next = decoded;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            header_reg <= '0;
            body0_reg  <= '0;
            body1_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            body0_reg  <= body0_next;
            body1_reg  <= body1_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign res_valid   = valid_reg;
    assign frame_kind  = result_reg.frame_kind;
    assign channel     = result_reg.channel;
    assign adc_value   = result_reg.adc_value;
    assign body_first  = result_reg.body_first;
    assign body_second = result_reg.body_second;

    // a new result only follows an accepted checksum item
    a_result_from_csum: assert property (@(posedge clk) disable iff (!rst_n)
        (!valid_reg || out_take) ##1 valid_reg
        |-> $past(rx_take) && $past(pos_reg) == POS_CSUM)
        else $error("result without checksum item");

    // the frame position always returns to hunting after a checksum item
    a_csum_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        rx_take && pos_reg == POS_CSUM |=> pos_reg == POS_HUNT)
        else $error("position did not return to hunting");

    // a pending result is never overwritten while stalled
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_stall |=> valid_reg && $stable(result_reg))
        else $error("stalled result changed");

    // only the checksum item is ever held back
    a_stall_only_csum: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> pos_reg == POS_CSUM && valid_reg)
        else $error("non-checksum item stalled");

endmodule

`default_nettype wire

@@ design/cfd_decode.sv @@
// frame decoder: turns a held header and two body bytes into one result
// depends on cfd_pkg
`default_nettype none

module cfd_decode
    import cfd_pkg::*;
(
    input  wire logic [7:0]  header,
    input  wire logic [7:0]  body0,
    input  wire logic [7:0]  body1,
    output cfd_result_t      result
);

    always_comb
    begin
        result = '0;
        unique case (header)
            HDR_ADC:
            begin
                result.frame_kind = KIND_ADC;
                result.channel    = body0[6:4];
                result.adc_value  = {body0[1:0], body1};
            end
            HDR_FREQ:
            begin
                result.frame_kind  = body0[7] ? KIND_FREQ : KIND_MASK;
                result.body_second = body1;
            end
            HDR_POWER:
            begin
                result.frame_kind  = KIND_POWER;
                result.body_first  = body0;
                result.body_second = body1;
            end
            HDR_EACK:
            begin
                result.frame_kind = KIND_EACK;
            end
            default:
            begin
                result.frame_kind = KIND_WACK;
            end
        endcase
    end

endmodule

`default_nettype wire
